// ===== hw/rtl/jfd_pkg.sv =====
// shared types, constants and arithmetic helpers of the face dissipation block
package jfd_pkg;

	localparam int WORD_W  = 32;
	localparam int FRAC    = 20;
	localparam int GAIN_SH = 17;
	localparam int NCELL   = 6;
	localparam int PROD_W  = 2 * WORD_W + 2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [WORD_W-2:0] unw_t;

	// conserved variable codes
	localparam logic [1:0] VAR_DEN = 2'd0;
	localparam logic [1:0] VAR_MX  = 2'd1;
	localparam logic [1:0] VAR_MY  = 2'd2;
	localparam logic [1:0] VAR_EN  = 2'd3;

	typedef struct packed {
		word_t den;
		word_t mx;
		word_t my;
		word_t en;
	} cons_t;

	typedef struct packed {
		cons_t cons;
		unw_t  p;
		word_t vx;
		word_t vy;
		unw_t  c;
		word_t fx;
		word_t fy;
	} cell_t;

	// one face job: cells one to four of the conserved state, all pressures,
	// averaging inputs from slots two and three, face vector of slot three
	typedef struct packed {
		cons_t [3:0]        cons;
		unw_t  [NCELL-1:0]  p;
		word_t              vx2;
		word_t              vx3;
		word_t              vy2;
		word_t              vy3;
		unw_t               c2;
		unw_t               c3;
		word_t              fx3;
		word_t              fy3;
	} job_t;

	function automatic word_t cons_get(cons_t c, logic [1:0] v);
		word_t r;
		case (v)
			VAR_DEN: r = c.den;
			VAR_MX:  r = c.mx;
			VAR_MY:  r = c.my;
			VAR_EN:  r = c.en;
			default: r = c.den;
		endcase
		return r;
	endfunction

	// saturate a wide signed value to the word range
	function automatic word_t sat_word(logic signed [WORD_W+3:0] x);
		logic signed [WORD_W+3:0] hi;
		logic signed [WORD_W+3:0] lo;
		word_t r;
		hi = (WORD_W+4)'(2 ** (WORD_W - 1) - 1);
		lo = -hi - (WORD_W+4)'(1);
		if (x > hi) r = {1'b0, {(WORD_W-1){1'b1}}};
		else if (x < lo) r = {1'b1, {(WORD_W-1){1'b0}}};
		else r = x[WORD_W-1:0];
		return r;
	endfunction

	// round an exact product to nearest, halves away from zero, and saturate
	function automatic word_t qround(logic signed [PROD_W-1:0] p, logic sh17);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		logic [PROD_W-1:0] lim;
		logic neg;
		word_t o;
		neg = p[PROD_W-1];
		mag = neg ? PROD_W'(-p) : PROD_W'(p);
		if (sh17) r = (mag + (PROD_W'(1) << (GAIN_SH - 1))) >> GAIN_SH;
		else r = (mag + (PROD_W'(1) << (FRAC - 1))) >> FRAC;
		lim = (PROD_W'(1) << (WORD_W - 1)) - PROD_W'(neg ? 0 : 1);
		if (r > lim) o = neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		else o = neg ? word_t'(-r[WORD_W-1:0]) : word_t'(r[WORD_W-1:0]);
		return o;
	endfunction

endpackage

// ===== hw/rtl/jfd_front.sv =====
// front end: six-cell window, fill tracking and face job issue
module jfd_front import jfd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  acc,
	input  logic  line_start,
	input  cell_t cell_in,
	output logic  push,
	output job_t  job
);

	cell_t      win_q [NCELL];
	logic [2:0] fill_q;
	cell_t      win_n [NCELL];
	logic [2:0] fill_n;

	always_comb begin
		for (int i = 0; i < NCELL - 1; i++) win_n[i] = line_start ? '0 : win_q[i + 1];
		win_n[NCELL-1] = cell_in;
		if (line_start) fill_n = 3'd1;
		else if (fill_q < 3'(NCELL)) fill_n = fill_q + 3'd1;
		else fill_n = fill_q;
	end

	assign push = acc && (fill_n == 3'(NCELL));

	always_comb begin
		for (int i = 0; i < 4; i++) job.cons[i] = win_n[i + 1].cons;
		for (int i = 0; i < NCELL; i++) job.p[i] = win_n[i].p;
		job.vx2 = win_n[2].vx;
		job.vx3 = win_n[3].vx;
		job.vy2 = win_n[2].vy;
		job.vy3 = win_n[3].vy;
		job.c2  = win_n[2].c;
		job.c3  = win_n[3].c;
		job.fx3 = win_n[3].fx;
		job.fy3 = win_n[3].fy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc) begin
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < NCELL; i++) win_q[i] <= win_n[i];
		end
	end

endmodule

// ===== hw/rtl/jfd_queue.sv =====
// two-entry job queue between front and back
module jfd_queue import jfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	job_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_job;
	end

endmodule

// ===== hw/rtl/jfd_back.sv =====
// back end: pressure sensor divider, shared multiplier sequence, result register
module jfd_back import jfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  job_t         q_head,
	output logic         q_pop,
	input  logic [15:0]  gain2,
	input  logic [15:0]  gain4,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [127:0] out_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DINIT = 3'd1;
	localparam logic [2:0] ST_DSTEP = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_RND   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [3:0] OP_UX   = 4'd0;
	localparam logic [3:0] OP_VY   = 4'd1;
	localparam logic [3:0] OP_G2   = 4'd2;
	localparam logic [3:0] OP_NU   = 4'd3;
	localparam logic [3:0] OP_G4   = 4'd4;
	localparam logic [3:0] OP_LAST = 4'd12;

	logic [2:0]  st_q;
	job_t        job_q;
	logic [1:0]  k_q;
	logic [4:0]  bit_q;
	logic [32:0] rem_q;
	logic [20:0] quo_q;
	logic [20:0] nu_q;
	logic [3:0]  op_q;
	logic signed [PROD_W-1:0] prod_q;
	word_t m1_q, lam_q, t_q, e2_q, e4_q, a_q;
	word_t res_q [4];
	logic         out_valid_q;
	logic [127:0] out_q;

	// sensor terms for window position k
	logic [32:0] p0, p1, p2;
	logic signed [34:0] snum;
	logic [32:0] num, den;
	logic [33:0] r2;
	logic [20:0] q2;
	logic [32:0] rem_n;

	always_comb begin
		p0 = 33'(job_q.p[3'(k_q)]);
		p1 = 33'(job_q.p[3'(k_q) + 3'd1]);
		p2 = 33'(job_q.p[3'(k_q) + 3'd2]);
		snum = $signed({2'b00, p2}) - $signed({1'b0, p1, 1'b0}) + $signed({2'b00, p0});
		num = snum[34] ? 33'(-snum) : snum[32:0];
		den = p2 + {p1[31:0], 1'b0} + p0;
		r2 = {rem_q, 1'b0};
		q2 = {quo_q[19:0], 1'b0};
		rem_n = r2[32:0];
		if (r2 >= {1'b0, den}) begin
			rem_n = 33'(r2 - {1'b0, den});
			q2[0] = 1'b1;
		end
	end

	// averages and differences
	word_t uavg, vavg, cavg, d1, d3;
	logic [1:0] var_sel;
	word_t w1, w2, w3, w4;
	logic signed [WORD_W:0] sx, sy;
	logic [WORD_W-1:0] sc;
	logic signed [WORD_W+3:0] dd1, dd3;

	always_comb begin
		sx = $signed({job_q.vx2[WORD_W-1], job_q.vx2}) + $signed({job_q.vx3[WORD_W-1], job_q.vx3});
		sy = $signed({job_q.vy2[WORD_W-1], job_q.vy2}) + $signed({job_q.vy3[WORD_W-1], job_q.vy3});
		sc = {1'b0, job_q.c2} + {1'b0, job_q.c3};
		uavg = sx[WORD_W:1];
		vavg = sy[WORD_W:1];
		cavg = word_t'({1'b0, sc[WORD_W-1:1]});
		var_sel = 2'((op_q - 4'd5) >> 1);
		w1 = cons_get(job_q.cons[0], var_sel);
		w2 = cons_get(job_q.cons[1], var_sel);
		w3 = cons_get(job_q.cons[2], var_sel);
		w4 = cons_get(job_q.cons[3], var_sel);
		dd1 = (WORD_W+4)'(w3) - (WORD_W+4)'(w2);
		dd3 = (WORD_W+4)'(w4) - 3 * (WORD_W+4)'(w3) + 3 * (WORD_W+4)'(w2) - (WORD_W+4)'(w1);
		d1 = sat_word(dd1);
		d3 = sat_word(dd3);
	end

	// shared multiplier operand selection
	logic signed [WORD_W:0] ma, mb;
	always_comb begin
		case (op_q)
			OP_UX: begin ma = (WORD_W+1)'(uavg); mb = (WORD_W+1)'(job_q.fx3); end
			OP_VY: begin ma = (WORD_W+1)'(vavg); mb = (WORD_W+1)'(job_q.fy3); end
			OP_G2: begin ma = (WORD_W+1)'(lam_q); mb = $signed((WORD_W+1)'(gain2)); end
			OP_NU: begin ma = (WORD_W+1)'(t_q); mb = $signed((WORD_W+1)'(nu_q)); end
			OP_G4: begin ma = (WORD_W+1)'(lam_q); mb = $signed((WORD_W+1)'(gain4)); end
			default: begin
				if (op_q[0]) begin ma = (WORD_W+1)'(e2_q); mb = (WORD_W+1)'(d1); end
				else begin ma = (WORD_W+1)'(e4_q); mb = (WORD_W+1)'(d3); end
			end
		endcase
	end

	word_t rnd, lam_a, lam_n, e4_s, res_n;
	always_comb begin
		rnd   = qround(prod_q, (op_q == OP_G2) || (op_q == OP_G4));
		lam_a = sat_word((WORD_W+4)'(m1_q) + (WORD_W+4)'(rnd));
		lam_n = sat_word((WORD_W+4)'(lam_a) + (WORD_W+4)'(cavg));
		e4_s  = sat_word((WORD_W+4)'(rnd) - (WORD_W+4)'(e2_q));
		res_n = sat_word((WORD_W+4)'(a_q) - (WORD_W+4)'(rnd));
	end

	assign q_pop     = (st_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (!q_empty) st_q <= ST_DINIT;
				ST_DINIT: begin
					if (den == '0) begin
						if (k_q == 2'd3) st_q <= ST_MUL;
					end else begin
						st_q <= ST_DSTEP;
					end
				end
				ST_DSTEP: if (bit_q == 5'(FRAC - 1)) st_q <= (k_q == 2'd3) ? ST_MUL : ST_DINIT;
				ST_MUL: st_q <= ST_RND;
				ST_RND: st_q <= (op_q == OP_LAST) ? ST_OUT : ST_MUL;
				ST_OUT: begin
					if (!out_valid_q || out_ready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				job_q <= q_head;
				k_q   <= '0;
				nu_q  <= '0;
				op_q  <= OP_UX;
			end
			ST_DINIT: begin
				bit_q <= '0;
				if (den == '0) begin
					k_q <= k_q + 2'd1;
				end else if (num >= den) begin
					rem_q <= num - den;
					quo_q <= 21'd1;
				end else begin
					rem_q <= num;
					quo_q <= 21'd0;
				end
			end
			ST_DSTEP: begin
				rem_q <= rem_n;
				quo_q <= q2;
				bit_q <= bit_q + 5'd1;
				if (bit_q == 5'(FRAC - 1)) begin
					if (q2 > nu_q) nu_q <= q2;
					k_q <= k_q + 2'd1;
				end
			end
			ST_MUL: prod_q <= PROD_W'(ma) * PROD_W'(mb);
			ST_RND: begin
				op_q <= op_q + 4'd1;
				case (op_q)
					OP_UX: m1_q <= rnd;
					OP_VY: lam_q <= lam_n;
					OP_G2: t_q <= rnd;
					OP_NU: e2_q <= rnd;
					OP_G4: e4_q <= e4_s[WORD_W-1] ? '0 : e4_s;
					default: begin
						if (op_q[0]) a_q <= rnd;
						else res_q[var_sel] <= res_n;
					end
				endcase
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) out_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/jameson_face_dissipation.sv =====
// top level of the jameson face dissipation block
// the job issued by the cell that fills the window passes the job queue, sensor divider and multiplier sequence
// the back end takes a new face only from idle; each sensor ratio uses bit-serial division,
//   skipped when its denominator is zero, then the shared multiplier sequence runs
// cells are taken one per cycle while the job queue has room
// reset: arst_n clears the window fill count, queue and sequencer; gains go to defaults
module jameson_face_dissipation import jfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// cell input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// density, momentum_x, momentum_y, total_energy, pressure, velocity_x,
	// velocity_y, sound_speed, face_sx, face_sy, then two zero bits
	input  logic [319:0] s_tdata,
	// line_start
	input  logic         s_tuser,
	// dissipation output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// diss_density, diss_momentum_x, diss_momentum_y, diss_energy
	output logic [127:0] m_tdata,
	// register write port
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam logic [1:0] REG_GAIN2 = 2'd0;
	localparam logic [1:0] REG_GAIN4 = 2'd1;

	logic [15:0] gain2_q, gain4_q;
	logic        acc, push, pop, q_empty, q_full;
	cell_t       in_cell;
	job_t        job, head;

	// unpack the cell fields from the lowest bit up
	always_comb begin
		in_cell.cons.den = s_tdata[31:0];
		in_cell.cons.mx  = s_tdata[63:32];
		in_cell.cons.my  = s_tdata[95:64];
		in_cell.cons.en  = s_tdata[127:96];
		in_cell.p        = s_tdata[158:128];
		in_cell.vx       = s_tdata[190:159];
		in_cell.vy       = s_tdata[222:191];
		in_cell.c        = s_tdata[253:223];
		in_cell.fx       = s_tdata[285:254];
		in_cell.fy       = s_tdata[317:286];
	end

	// a cell is taken only while the queue can hold the job it may issue
	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	// gain registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain2_q <= 16'd16384;
			gain4_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN2: gain2_q <= cfg_data;
				REG_GAIN4: gain4_q <= cfg_data;
				default: ;
			endcase
		end
	end

	jfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.line_start (s_tuser),
		.cell_in    (in_cell),
		.push       (push),
		.job        (job)
	);

	jfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	jfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head),
		.q_pop     (pop),
		.gain2     (gain2_q),
		.gain4     (gain4_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
